>>> sv/clas_pkg.sv
// ----------------------------------------------------------------------------
// clas_pkg
// Shared types, character codes and helpers for the argument splitter.
// ----------------------------------------------------------------------------
package clas_pkg;

    // Longest backslash run that is counted; longer runs lose backslashes.
    localparam int SLASH_COUNT_MAX = 31;
    localparam int SLASH_W         = $clog2(SLASH_COUNT_MAX + 1);

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int   CFG_AW        = 3;
    localparam logic REG_ARG_LIMIT = 1'b0;   // register index, paddr[2]
    localparam logic [7:0] ARG_LIMIT_RST = 8'd32;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [7:0] arg_index;
        logic       final_res;
    } t_res;

    typedef enum logic [1:0] {
        MODE_LEAD  = 2'd0,
        MODE_SEP   = 2'd1,
        MODE_TEXT  = 2'd2,
        MODE_SLASH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SEP   = 3'd1,
        PH_SLASH = 3'd2,
        PH_CHAR  = 3'd3,
        PH_END   = 3'd4
    } t_phase;

    // Work for one input byte, in emission order:
    // separator end, backslashes, one character, closing end mark.
    typedef struct packed {
        logic               sep_end;
        logic [SLASH_W-1:0] n_slash;
        logic               has_char;
        logic [7:0]         ch;
        logic               tail_end;
        logic               last;
        logic [7:0]         base_idx;
    } t_cmd;

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

>>> sv/clas_front.sv
// ----------------------------------------------------------------------------
// clas_front
// Classifies each input byte against the quoting and backslash state and
// turns it into a work command for the emitter.
// ----------------------------------------------------------------------------
module clas_front
    import clas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in_data,
    output logic o_in_stall,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_cmd
);

    t_mode              r_mode;
    logic               r_quoted;
    logic [SLASH_W-1:0] r_sn;
    logic [7:0]         r_aidx;
    logic               r_lend;

    t_mode              w_mode_step;
    logic               w_q_step;
    logic [SLASH_W-1:0] w_sn_step;
    logic               w_flush;
    logic               w_lend_step;
    logic               w_accept;
    logic               w_blank;
    logic               w_bs;
    logic               w_qt;
    logic               w_sep;
    logic               w_do_text;
    t_cmd               w_cmd;
    logic [7:0]         c;
    logic               last;

    assign c       = i_in_data.in_byte;
    assign last    = i_in_data.line_end;
    assign w_blank = (c == CH_SPACE) || (c == CH_TAB);
    assign w_bs    = (c == CH_BSLASH);
    assign w_qt    = (c == CH_QUOTE);

    assign w_sep     = (r_mode == MODE_SEP) && !w_blank;
    assign w_do_text = ((r_mode == MODE_LEAD) && !w_blank) || w_sep ||
                       (r_mode == MODE_TEXT) ||
                       ((r_mode == MODE_SLASH) && !w_bs && !w_qt);

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // next state
    always_comb begin
        w_mode_step = r_mode;
        w_q_step    = r_quoted;
        w_sn_step   = r_sn;
        unique case (r_mode)
            MODE_SLASH: begin
                if (w_bs) begin
                    if (r_sn != SLASH_W'(SLASH_COUNT_MAX))
                        w_sn_step = r_sn + SLASH_W'(1);
                end else if (w_qt) begin
                    if (!r_sn[0])
                        w_q_step = !r_quoted;
                    w_sn_step   = '0;
                    w_mode_step = MODE_TEXT;
                end else begin
                    w_sn_step = '0;
                end
            end
            default: ;
        endcase
        if (w_do_text) begin
            w_mode_step = MODE_TEXT;
            if (w_blank) begin
                if (!r_quoted)
                    w_mode_step = MODE_SEP;
            end else if (w_bs) begin
                w_mode_step = MODE_SLASH;
                w_sn_step   = SLASH_W'(1);
            end else if (w_qt) begin
                w_q_step = !r_quoted;
            end
        end
        // pending run at line end is copied as is
        w_flush = last && (w_mode_step == MODE_SLASH);
        if (w_flush)
            w_mode_step = MODE_TEXT;
    end

    // outputs
    always_comb begin
        w_cmd          = '0;
        w_cmd.ch       = c;
        w_cmd.base_idx = r_aidx;
        w_cmd.last     = last;
        w_cmd.sep_end  = w_sep;
        if ((r_mode == MODE_SLASH) && w_qt) begin
            w_cmd.n_slash = r_sn >> 1;
            if (r_sn[0]) begin
                w_cmd.has_char = 1'b1;
                w_cmd.ch       = CH_QUOTE;
            end
        end else if ((r_mode == MODE_SLASH) && !w_bs) begin
            w_cmd.n_slash = r_sn;
        end
        if (w_do_text) begin
            if (w_blank)
                w_cmd.has_char = r_quoted;
            else if (w_qt)
                w_cmd.tail_end = r_quoted && last;   // closing quote ends the line
            else if (!w_bs)
                w_cmd.has_char = 1'b1;
        end
        if (w_flush)
            w_cmd.n_slash = w_sn_step;

        if (w_cmd.tail_end)
            w_lend_step = 1'b1;
        else if (w_cmd.has_char || (w_cmd.n_slash != '0))
            w_lend_step = 1'b0;
        else if (w_cmd.sep_end)
            w_lend_step = 1'b1;
        else
            w_lend_step = r_lend;

        if (last && ((w_mode_step == MODE_SEP) || !w_lend_step || w_q_step))
            w_cmd.tail_end = 1'b1;
    end

    assign o_cmd  = w_cmd;
    assign o_push = w_accept && (w_cmd.sep_end || w_cmd.has_char || w_cmd.tail_end ||
                                 (w_cmd.n_slash != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LEAD;
            r_quoted <= 1'b0;
            r_sn     <= '0;
            r_aidx   <= '0;
            r_lend   <= 1'b0;
        end else if (w_accept) begin
            if (last) begin
                r_mode   <= MODE_LEAD;
                r_quoted <= 1'b0;
                r_sn     <= '0;
                r_aidx   <= '0;
                r_lend   <= 1'b0;
            end else begin
                r_mode   <= w_mode_step;
                r_quoted <= w_q_step;
                r_sn     <= w_sn_step;
                r_aidx   <= w_sep ? sat_inc(r_aidx) : r_aidx;
                r_lend   <= w_lend_step;
            end
        end
    end

endmodule

>>> sv/clas_queue.sv
// ----------------------------------------------------------------------------
// clas_queue
// Small command FIFO between the classifier and the emitter.
// ----------------------------------------------------------------------------
module clas_queue
    import clas_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= ptr_inc(r_wr);
            if (i_pop)
                r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)
                r_count <= r_count + CW'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - CW'(1);
        end
    end

endmodule

>>> sv/clas_back.sv
// ----------------------------------------------------------------------------
// clas_back
// Expands commands into result transactions, one per cycle unless stalled,
// applies the argument limit and drives the registered output.
// ----------------------------------------------------------------------------
module clas_back
    import clas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_arg_limit,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_res       o_out_data,
    input  logic       i_out_stall
);

    t_phase             r_phase;
    t_cmd               r_cmd;
    logic [SLASH_W-1:0] r_cnt;
    logic [7:0]         r_idx;
    logic               r_out_valid;
    t_res               r_out;

    t_phase             n_phase;
    t_cmd               n_cmd;
    logic [SLASH_W-1:0] n_cnt;
    logic [7:0]         n_idx;

    logic   w_out_free;
    logic   w_act;
    t_phase w_nxt;
    logic   w_keep;
    logic   w_load;
    t_res   w_res;

    // first piece of work in c that comes after piece 'after'
    function automatic t_phase next_piece(t_cmd c, t_phase after);
        t_phase p;
        p = PH_IDLE;
        if ((after < PH_SEP) && c.sep_end)
            p = PH_SEP;
        else if ((after < PH_SLASH) && (c.n_slash != '0))
            p = PH_SLASH;
        else if ((after < PH_CHAR) && c.has_char)
            p = PH_CHAR;
        else if ((after < PH_END) && c.tail_end)
            p = PH_END;
        return p;
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_act      = (r_phase != PH_IDLE) && w_out_free;
    assign w_nxt      = ((r_phase != PH_SLASH) || (r_cnt == SLASH_W'(1))) ?
                        next_piece(r_cmd, r_phase) : r_phase;
    assign o_pop      = i_q_valid && ((r_phase == PH_IDLE) || (w_act && (w_nxt == PH_IDLE)));

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        if (w_act) begin
            n_phase = w_nxt;
            if (r_phase == PH_SLASH)
                n_cnt = r_cnt - SLASH_W'(1);
            if (r_phase == PH_SEP)
                n_idx = sat_inc(r_idx);
        end
        if (o_pop) begin
            n_cmd   = i_q_cmd;
            n_phase = next_piece(i_q_cmd, PH_IDLE);
            n_cnt   = i_q_cmd.n_slash;
            n_idx   = i_q_cmd.base_idx;
        end
    end

    // outputs
    always_comb begin
        w_keep          = ({1'b0, r_idx} + 9'd1) < {1'b0, i_arg_limit};
        w_res.arg_index = r_idx;
        w_res.final_res = 1'b0;
        w_res.kind      = KIND_END;
        w_res.out_byte  = 8'h00;
        unique case (r_phase)
            PH_SLASH: begin
                w_res.kind     = KIND_CHAR;
                w_res.out_byte = CH_BSLASH;
            end
            PH_CHAR: begin
                w_res.kind     = KIND_CHAR;
                w_res.out_byte = r_cmd.ch;
            end
            PH_END: begin
                w_res.final_res = r_cmd.last;
                // dropped last end mark is replaced by the terminator slot
                if (!w_keep)
                    w_res.arg_index = (i_arg_limit == 8'd0) ? 8'd0 : i_arg_limit - 8'd1;
            end
            default: ;
        endcase
        w_load = w_act && (w_keep || ((r_phase == PH_END) && r_cmd.last));
    end

    always_ff @(posedge i_clk) begin
        if (w_load)
            r_out <= w_res;
        r_cmd <= n_cmd;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_slash_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SLASH) |-> (r_cnt != '0))
        else $error("backslash phase with empty count");

    a_final_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.final_res) |-> (r_out.kind == KIND_END) && (r_out.out_byte == 8'h00))
        else $error("final result is not an end mark");

    a_end_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_END) |-> r_cmd.tail_end)
        else $error("end phase without end work");

endmodule

>>> sv/command_line_argument_splitter_core.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter_core
// Splits a byte stream of command lines into argument characters and
// argument-end marks.
// ----------------------------------------------------------------------------
// Input channel: one command-line byte per transaction, line_end set on the
// last byte. Output channel: one result per transaction (character or end
// mark), final_res set on the last result of the line. Both use valid/stall.
// Configuration: arg_limit at APB address 0; write only while idle.
// Path of a byte: command queue, emitter command register, output register.
// Throughput: the emitter produces one result per cycle while the receiver
// does not stall; a byte that yields no result costs one input cycle only.
// A byte closing a backslash run emits up to SLASH_COUNT_MAX + 2 results.
// Bytes keep being accepted until the QUEUE_DEPTH-entry command queue fills;
// then the input is stalled. Receiver stall holds the output register and,
// through the queue, eventually the input.
// Reset: synchronous, active low; arg_limit returns to 32, parser state,
// queue and output are cleared.
// ----------------------------------------------------------------------------
module command_line_argument_splitter_core
    import clas_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in               i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_res              o_out_data,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_arg_limit;
    logic       w_push;
    logic       w_pop;
    logic       w_q_valid;
    logic       w_q_full;
    t_cmd       w_push_cmd;
    t_cmd       w_q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARG_LIMIT) ? {24'h0, r_arg_limit} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_arg_limit <= ARG_LIMIT_RST;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_ARG_LIMIT))
            r_arg_limit <= pwdata[7:0];
    end

    clas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    clas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_q_cmd)
    );

    clas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_arg_limit (r_arg_limit),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> test/tb_command_line_argument_splitter_core.sv
// ----------------------------------------------------------------------------
// tb_command_line_argument_splitter_core
// Self-checking bench for the command-line argument splitter. Command lines
// are fed one byte per transaction. A scoreboard class tracks the splitter's
// parse state and predicts the argument characters and end marks for each
// accepted byte. Every result is compared with the oldest prediction. The
// bench steps through several arg_limit settings and applies random idle
// gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_command_line_argument_splitter_core
    import clas_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 150;
    localparam logic [CFG_AW-1:0] ARG_LIMIT_ADDR = CFG_AW'({REG_ARG_LIMIT, 2'b00});

    class split_tracker;
        t_res        awaited_results[$];
        t_res        step_res[$];
        t_mode       mode;
        bit          quoted;
        int unsigned slash_n;
        int unsigned arg_idx;
        bit          last_end;
        int unsigned arg_limit;
        int          mismatches;
        int          checked;

        function new();
            arg_limit  = ARG_LIMIT_RST;
            mismatches = 0;
            checked    = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode     = MODE_LEAD;
            quoted   = 1'b0;
            slash_n  = 0;
            arg_idx  = 0;
            last_end = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        // Results of arguments at index arg_limit-1 and above are dropped but still count.
        function bit push_res(logic kind, logic [7:0] ch);
            bit   keep;
            t_res r;
            keep = (arg_idx + 1) < arg_limit;
            if (keep) begin
                r.kind      = kind;
                r.out_byte  = (kind == KIND_END) ? 8'h00 : ch;
                r.arg_index = 8'(arg_idx);
                r.final_res = 1'b0;
                step_res.push_back(r);
            end
            if (kind == KIND_END) begin
                last_end = 1'b1;
                if (arg_idx < 255) arg_idx++;
            end else begin
                last_end = 1'b0;
            end
            return keep;
        endfunction

        function void push_slashes(int unsigned n);
            repeat (n) void'(push_res(KIND_CHAR, CH_BSLASH));
        endfunction

        function void text_byte(logic [7:0] c, bit last);
            mode = MODE_TEXT;
            if (is_blank(c)) begin
                if (quoted) void'(push_res(KIND_CHAR, c));
                else mode = MODE_SEP;
            end else if (c == CH_BSLASH) begin
                mode    = MODE_SLASH;
                slash_n = 1;
            end else if (c == CH_QUOTE) begin
                quoted = !quoted;
                if (!quoted && last) void'(push_res(KIND_END, 8'h00));
            end else begin
                void'(push_res(KIND_CHAR, c));
            end
        endfunction

        function void accept_byte(t_in item);
            logic [7:0] c;
            bit         last;
            bit         kept;
            t_res       r;
            c    = item.in_byte;
            last = item.line_end;
            step_res.delete();
            case (mode)
                MODE_LEAD: begin
                    if (!is_blank(c)) text_byte(c, last);
                end
                MODE_SEP: begin
                    // held-back separator end mark goes out on the next non-blank
                    if (!is_blank(c)) begin
                        void'(push_res(KIND_END, 8'h00));
                        text_byte(c, last);
                    end
                end
                MODE_TEXT: begin
                    text_byte(c, last);
                end
                default: begin
                    if (c == CH_BSLASH) begin
                        if (slash_n < SLASH_COUNT_MAX) slash_n++;
                    end else if (c == CH_QUOTE) begin
                        push_slashes(slash_n / 2);
                        if ((slash_n % 2) != 0) void'(push_res(KIND_CHAR, CH_QUOTE));
                        else quoted = !quoted;
                        slash_n = 0;
                        mode    = MODE_TEXT;
                    end else begin
                        push_slashes(slash_n);
                        slash_n = 0;
                        text_byte(c, last);
                    end
                end
            endcase

            if (last) begin
                if (mode == MODE_SLASH) begin
                    push_slashes(slash_n);
                    slash_n = 0;
                    mode    = MODE_TEXT;
                end
                if (mode == MODE_SEP || !last_end || quoted)
                    kept = push_res(KIND_END, 8'h00);
                else
                    kept = step_res.size() > 0;
                if (kept && step_res.size() > 0) begin
                    r = step_res.pop_back();
                    r.final_res = 1'b1;
                    step_res.push_back(r);
                end else begin
                    // terminator in place of a dropped final end mark
                    r.kind      = KIND_END;
                    r.out_byte  = 8'h00;
                    r.arg_index = (arg_limit == 0) ? 8'h00 : 8'(arg_limit - 1);
                    r.final_res = 1'b1;
                    step_res.push_back(r);
                end
                clear_line();
            end
            foreach (step_res[i]) awaited_results.push_back(step_res[i]);
        endfunction

        function void check_result(t_res got);
            t_res exp;
            checked++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: kind %0d byte %02h idx %0d final %0d",
                             $realtime, got.kind, got.out_byte, got.arg_index, got.final_res);
                return;
            end
            exp = awaited_results.pop_front();
            if (got.kind !== exp.kind || got.out_byte !== exp.out_byte ||
                got.arg_index !== exp.arg_index || got.final_res !== exp.final_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] result mismatch: exp kind %0d byte %02h idx %0d final %0d",
                             $realtime, exp.kind, exp.out_byte, exp.arg_index, exp.final_res);
                    $display("[%0t]                  got kind %0d byte %02h idx %0d final %0d",
                             $realtime, got.kind, got.out_byte, got.arg_index, got.final_res);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    t_in               i_in_data;
    logic              o_in_stall;
    logic              o_out_valid;
    t_res              o_out_data;
    logic              i_out_stall;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    split_tracker splitter = new();
    logic [7:0]   line_q[$];
    bit           steady;
    int           hold_request;
    int           rx_hold_left;
    int           cycle_count;
    int           cfg_errors;
    int           lines_sent;
    int           bytes_sent;
    int           rand_limit;

    command_line_argument_splitter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_command_line_argument_splitter_core: done, errors");
        $finish;
    end

    // Output side: check accepted results, random stalls, long holds on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold_left = 0;
        end else begin
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
                splitter.check_result(o_out_data);
            if (hold_request > 0) begin
                rx_hold_left = hold_request;
                hold_request = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(0, 99) < 15);
            end
        end
    end

    task automatic send_byte(t_in item);
        int gap;
        if (!steady && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        splitter.accept_byte(item);
        bytes_sent++;
    endtask

    task automatic send_line();
        t_in item;
        foreach (line_q[i]) begin
            item.in_byte  = line_q[i];
            item.line_end = (i == line_q.size() - 1);
            send_byte(item);
        end
        lines_sent++;
    endtask

    task automatic send_text(string s);
        line_q.delete();
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line();
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (splitter.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_arg_limit(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ARG_LIMIT_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== value) begin
            cfg_errors++;
            $display("[%0t] arg_limit readback: exp %0d got %0d", $realtime, value, prdata[7:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        splitter.arg_limit = value;
    endtask

    function automatic logic [7:0] word_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] blank_char();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic void add_word(int lo, int hi);
        repeat ($urandom_range(lo, hi)) line_q.push_back(word_char());
    endfunction

    // Mostly well-formed argument lists; one line in five is byte noise.
    function automatic void build_line();
        int n_tok;
        int run;
        line_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 4))
                    0: line_q.push_back(CH_SPACE);
                    1: line_q.push_back(CH_TAB);
                    2: line_q.push_back(CH_BSLASH);
                    3: line_q.push_back(CH_QUOTE);
                    default: line_q.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) line_q.push_back(blank_char());
            n_tok = $urandom_range(1, 6);
            for (int k = 0; k < n_tok; k++) begin
                case ($urandom_range(0, 5))
                    0, 1: add_word(1, 5);
                    2: begin
                        line_q.push_back(CH_QUOTE);
                        add_word(0, 3);
                        line_q.push_back(blank_char());
                        add_word(0, 3);
                        if ($urandom_range(0, 9) != 0) line_q.push_back(CH_QUOTE);
                    end
                    3: begin
                        // occasional runs beyond the saturating count
                        run = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 40)
                                                          : $urandom_range(1, 4);
                        repeat (run) line_q.push_back(CH_BSLASH);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4: line_q.push_back(CH_QUOTE);
                            5, 6, 7: line_q.push_back(word_char());
                            default: ;
                        endcase
                    end
                    4: begin
                        add_word(0, 2);
                        line_q.push_back(CH_QUOTE);
                        line_q.push_back(CH_QUOTE);
                    end
                    default: line_q.push_back(8'($urandom_range(1, 255)));
                endcase
                if (k < n_tok - 1)
                    repeat ($urandom_range(1, 2)) line_q.push_back(blank_char());
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) line_q.push_back(blank_char());
        end
        if (line_q.size() == 0) line_q.push_back(8'h61);
    endfunction

    task automatic random_lines(int budget);
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < budget) begin
            build_line();
            send_line();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        steady       = 1'b0;
        hold_request = 0;
        cfg_errors   = 0;
        lines_sent   = 0;
        bytes_sent   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines at the reset value of arg_limit
        send_text(" \ta");
        send_text("\\q b ");
        send_text("\"\"");
        send_text("\\\\\\\"\\\\\"\\");
        send_text(" \t");
        line_q = '{8'hFF, 8'h01};
        send_line();
        // more arguments than the reset table holds
        line_q.delete();
        for (int i = 0; i < 40; i++) begin
            line_q.push_back(8'h7A);
            if (i < 39) line_q.push_back(CH_SPACE);
        end
        send_line();
        drain_results();

        // widest table
        write_arg_limit(8'd255);
        random_lines(30);
        drain_results();

        write_arg_limit(8'd1);
        random_lines(30);
        drain_results();

        steady = 1'b1;
        write_arg_limit(8'd2);
        random_lines(30);
        drain_results();
        steady = 1'b0;

        write_arg_limit(8'd3);
        random_lines(30);
        drain_results();

        rand_limit = $urandom_range(4, 254);
        write_arg_limit(8'(rand_limit));
        random_lines(25);
        drain_results();
        random_lines(25);
        drain_results();

        // receiver holds off while bytes keep coming
        write_arg_limit(ARG_LIMIT_RST);
        hold_request = LONG_HOLD;
        random_lines(30);
        drain_results();

        if (splitter.awaited_results.size() != 0) begin
            splitter.mismatches++;
            $display("%0d expected results never arrived", splitter.awaited_results.size());
        end
        $display("covered %0d command lines, %0d bytes, %0d results checked",
                 lines_sent, bytes_sent, splitter.checked);
        $display("arg_limit settings 32, 255, 1, 2, 3, %0d; %0d mismatches, %0d register errors",
                 rand_limit, splitter.mismatches, cfg_errors);
        if (splitter.mismatches == 0 && cfg_errors == 0) begin
            $display("tb_command_line_argument_splitter_core: done, clean");
        end else begin
            $display("tb_command_line_argument_splitter_core: done, errors");
        end
        $finish;
    end

endmodule
